[design/pl0rme_pkg.sv]
package pl0rme_pkg;

    // Opcodes
    localparam logic [4:0] OP_LIT = 5'd1;
    localparam logic [4:0] OP_RTN = 5'd2;
    localparam logic [4:0] OP_LOD = 5'd3;
    localparam logic [4:0] OP_STO = 5'd4;
    localparam logic [4:0] OP_CAL = 5'd5;
    localparam logic [4:0] OP_INC = 5'd6;
    localparam logic [4:0] OP_JMP = 5'd7;
    localparam logic [4:0] OP_JPC = 5'd8;
    localparam logic [4:0] OP_OUT = 5'd9;
    localparam logic [4:0] OP_IN  = 5'd10;
    localparam logic [4:0] OP_HLT = 5'd11;
    localparam logic [4:0] OP_NEG = 5'd12;
    localparam logic [4:0] OP_ADD = 5'd13;
    localparam logic [4:0] OP_SUB = 5'd14;
    localparam logic [4:0] OP_MUL = 5'd15;
    localparam logic [4:0] OP_DIV = 5'd16;
    localparam logic [4:0] OP_ODD = 5'd17;
    localparam logic [4:0] OP_MOD = 5'd18;
    localparam logic [4:0] OP_EQL = 5'd19;
    localparam logic [4:0] OP_NEQ = 5'd20;
    localparam logic [4:0] OP_LSS = 5'd21;
    localparam logic [4:0] OP_LEQ = 5'd22;
    localparam logic [4:0] OP_GTR = 5'd23;
    localparam logic [4:0] OP_GEQ = 5'd24;

    // Error codes
    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_OPCODE = 3'd1;
    localparam logic [2:0] ERR_ZDIV   = 3'd2;
    localparam logic [2:0] ERR_STACK  = 3'd3;
    localparam logic [2:0] ERR_PC     = 3'd4;

    // Frame events
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_CALL = 2'd1;
    localparam logic [1:0] EV_RET  = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_IDX1,
        S_IDX2,
        S_IDX3,
        S_READ,
        S_READ_R,
        S_DISPATCH,
        S_WALK,
        S_WALK_DATA,
        S_LOD_ADDR,
        S_RTN_CHK,
        S_RTN_NB,
        S_DIV,
        S_EXEC,
        S_CAL_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clr;
        logic latch;
        logic show_halt;
        logic rd_ab;
        logic rd_r;
        logic walk_rd;
        logic walk_take;
        logic lod_rd;
        logic rtn_rd3;
        logic rtn_rd4;
        logic div_start;
        logic div_step;
        logic exec;
        logic cal_wr;
        logic stack_fault;
    } t_cmd;

    typedef struct packed {
        logic [4:0] op;
        logic       halted;
        logic       clr_last;
        logic       walk_zero;
        logic       walk_addr_bad;
        logic       link_bad;
        logic       lod_bad;
        logic       rtn_bad;
        logic       b_zero;
        logic       div_last;
        logic       cal_go;
        logic       cal_last;
    } t_stat;

endpackage

[design/pl0_register_machine_execute_top.sv]
// Sequence: accept, fold register numbers, read registers, dispatch, execute, result;
//   LOD/STO/CAL walk static links first, LOD then reads the stack, CAL writes its frame,
//   RTN reads its return frame, DIV/MOD run the divider. A halted machine shows its result
//   in the cycle right after accept. Throughput: one item at a time, none taken while a
//   result waits; link walk, single-port stack RAM and one-bit-per-cycle divider slow items.
// Reset: synchronous, active low. After reset a clearing pass over max(STACK_DEPTH,
//   REG_COUNT) addresses zeroes the stack and register file; no item is taken meanwhile.
module pl0_register_machine_execute_top
    import pl0rme_pkg::*;
#(
    parameter int STACK_DEPTH = 2048,
    parameter int CODE_DEPTH  = 512,
    parameter int REG_COUNT   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // instruction item
    input  logic               i_valid,
    output logic               o_ready,
    input  logic        [4:0]  i_opcode,
    input  logic        [3:0]  i_reg_index,
    input  logic        [3:0]  i_level,
    input  logic signed [31:0] i_operand_m,
    input  logic signed [31:0] i_in_value,
    // result item
    output logic               o_valid,
    input  logic               i_ready,
    output logic        [8:0]  o_pc_out,
    output logic        [10:0] o_bp_out,
    output logic        [10:0] o_sp_out,
    output logic               o_out_valid,
    output logic signed [31:0] o_out_value,
    output logic               o_halted,
    output logic        [2:0]  o_error_code,
    output logic        [1:0]  o_frame_event
);

    // The controller sequences each item: fold the register numbers, read the
    // register file, then walk static links, fetch the return frame or run the
    // divider as the opcode needs, then commit or flag an error, and for CAL write the frame.
    t_cmd  w_cmd;
    t_stat w_stat;

    pl0rme_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Datapath holds all architectural state: register file, stack RAM,
    // pc/bp/sp, halt flag, the divider and the result registers.
    pl0rme_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .CODE_DEPTH  (CODE_DEPTH),
        .REG_COUNT   (REG_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_opcode      (i_opcode),
        .i_reg_index   (i_reg_index),
        .i_level       (i_level),
        .i_operand_m   (i_operand_m),
        .i_in_value    (i_in_value),
        .o_pc_out      (o_pc_out),
        .o_bp_out      (o_bp_out),
        .o_sp_out      (o_sp_out),
        .o_out_valid   (o_out_valid),
        .o_out_value   (o_out_value),
        .o_halted      (o_halted),
        .o_error_code  (o_error_code),
        .o_frame_event (o_frame_event)
    );

endmodule

[design/pl0rme_ctrl.sv]
module pl0rme_ctrl
    import pl0rme_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = i_stat.halted ? S_DONE : S_IDX1;
            end
            S_IDX1:   n_state = S_IDX2;
            S_IDX2:   n_state = S_IDX3;
            S_IDX3:   n_state = S_READ;
            S_READ:   n_state = S_READ_R;
            S_READ_R: n_state = S_DISPATCH;
            S_DISPATCH: begin
                if (i_stat.op == OP_LOD || i_stat.op == OP_STO || i_stat.op == OP_CAL) begin
                    n_state = S_WALK;
                end else if (i_stat.op == OP_RTN) begin
                    n_state = S_RTN_CHK;
                end else if ((i_stat.op == OP_DIV || i_stat.op == OP_MOD) && !i_stat.b_zero) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_WALK: begin
                if (i_stat.walk_zero) begin
                    n_state = (i_stat.op == OP_LOD) ? S_LOD_ADDR : S_EXEC;
                end else if (i_stat.walk_addr_bad) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_WALK_DATA;
                end
            end
            S_WALK_DATA: n_state = i_stat.link_bad ? S_DONE : S_WALK;
            S_LOD_ADDR:  n_state = i_stat.lod_bad ? S_DONE : S_EXEC;
            S_RTN_CHK:   n_state = i_stat.rtn_bad ? S_DONE : S_RTN_NB;
            S_RTN_NB:    n_state = S_EXEC;
            S_DIV: begin
                if (i_stat.div_last) n_state = S_EXEC;
            end
            S_EXEC:   n_state = i_stat.cal_go ? S_CAL_WR : S_DONE;
            S_CAL_WR: begin
                if (i_stat.cal_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.clr = 1'b1;
            S_IDLE: begin
                o_ready         = 1'b1;
                o_cmd.latch     = i_valid;
                o_cmd.show_halt = i_valid && i_stat.halted;
            end
            S_READ:   o_cmd.rd_ab = 1'b1;
            S_READ_R: o_cmd.rd_r  = 1'b1;
            S_DISPATCH: begin
                o_cmd.div_start = (i_stat.op == OP_DIV || i_stat.op == OP_MOD) && !i_stat.b_zero;
            end
            S_WALK: begin
                if (!i_stat.walk_zero) begin
                    o_cmd.stack_fault = i_stat.walk_addr_bad;
                    o_cmd.walk_rd     = !i_stat.walk_addr_bad;
                end
            end
            S_WALK_DATA: begin
                o_cmd.stack_fault = i_stat.link_bad;
                o_cmd.walk_take   = !i_stat.link_bad;
            end
            S_LOD_ADDR: begin
                o_cmd.stack_fault = i_stat.lod_bad;
                o_cmd.lod_rd      = !i_stat.lod_bad;
            end
            S_RTN_CHK: begin
                o_cmd.stack_fault = i_stat.rtn_bad;
                o_cmd.rtn_rd3     = !i_stat.rtn_bad;
            end
            S_RTN_NB: o_cmd.rtn_rd4  = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_EXEC:   o_cmd.exec     = 1'b1;
            S_CAL_WR: o_cmd.cal_wr   = 1'b1;
            S_DONE:   o_valid        = 1'b1;
            default:  o_cmd          = '0;
        endcase
    end

endmodule

[design/pl0rme_dp.sv]
module pl0rme_dp
    import pl0rme_pkg::*;
#(
    parameter int STACK_DEPTH = 2048,
    parameter int CODE_DEPTH  = 512,
    parameter int REG_COUNT   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic        [4:0]  i_opcode,
    input  logic        [3:0]  i_reg_index,
    input  logic        [3:0]  i_level,
    input  logic signed [31:0] i_operand_m,
    input  logic signed [31:0] i_in_value,
    output logic        [8:0]  o_pc_out,
    output logic        [10:0] o_bp_out,
    output logic        [10:0] o_sp_out,
    output logic               o_out_valid,
    output logic signed [31:0] o_out_value,
    output logic               o_halted,
    output logic        [2:0]  o_error_code,
    output logic        [1:0]  o_frame_event
);

    localparam int SPW   = $clog2(STACK_DEPTH);
    localparam int PCW   = $clog2(CODE_DEPTH);
    localparam int RW    = $clog2(REG_COUNT);
    localparam int CLR_N = (STACK_DEPTH > REG_COUNT) ? STACK_DEPTH : REG_COUNT;
    localparam int CW    = $clog2(CLR_N);
    // residues of 256^k, used to fold the 32-bit register number
    localparam int C1    = 256 % REG_COUNT;
    localparam int C2    = (C1 * 256) % REG_COUNT;
    localparam int C3    = (C2 * 256) % REG_COUNT;
    localparam int RSH   = 23;
    localparam int KR    = ((1 << RSH) + REG_COUNT - 1) / REG_COUNT;

    localparam logic signed [33:0] SD34 = 34'(STACK_DEPTH);
    localparam logic [SPW:0]       SDW  = (SPW + 1)'(STACK_DEPTH);

    function automatic logic [RW-1:0] f_small_mod(input logic [3:0] x);
        logic [6:0] v;
        v = 7'(x);
        for (int i = 0; i < 4; i++) begin
            if (v >= 7'(REG_COUNT)) v = v - 7'(REG_COUNT);
        end
        return v[RW-1:0];
    endfunction

    logic [31:0] r_stack [STACK_DEPTH];
    logic [31:0] r_rf    [REG_COUNT];

    logic [4:0]     r_op;
    logic [RW-1:0]  r_ir, r_ia, r_ib;
    logic [3:0]     r_lv;
    logic [31:0]    r_m, r_inv;
    logic [15:0]    r_s1, r_s1d;
    logic [13:0]    r_qi;
    logic [31:0]    r_a, r_b, r_rv, r_q, r_nb;
    logic [SPW-1:0] r_cur;
    logic [3:0]     r_cnt;
    logic [PCW-1:0] r_pc;
    logic [SPW-1:0] r_bp, r_sp;
    logic           r_halt;
    logic [2:0]     r_err;
    logic [1:0]     r_event;
    logic           r_outv;
    logic [31:0]    r_oval;
    logic [31:0]    r_dvd, r_dvs, r_rem;
    logic [4:0]     r_dcnt;
    logic           r_qneg, r_rneg;
    logic [1:0]     r_k;
    logic [SPW-1:0] r_cal_bp;
    logic [PCW-1:0] r_cal_ret;
    logic [CW-1:0]  r_clr;

    // exec results
    logic [2:0]     n_err;
    logic           n_wreg, n_stop, n_outv, n_sto;
    logic [31:0]    n_wval, n_oval;
    logic [PCW-1:0] n_pc;
    logic [SPW-1:0] n_bp, n_sp;
    logic [1:0]     n_event;

    logic [37:0]        w_prod;
    logic [15:0]        w_rem16;
    logic signed [33:0] w_tsum, w_isum;
    logic               w_t_ok, w_i_ok, w_m_code;
    logic [PCW-1:0]     w_npc;
    logic [SPW:0]       w_sp4, w_cur1, w_bp3;
    logic signed [31:0] w_sa, w_sb;
    logic [32:0]        w_shift, w_diff;
    logic [31:0]        w_quot, w_remv;
    logic               w_clr_stk, w_clr_rf;
    logic               w_we, w_re;
    logic [SPW-1:0]     w_addr;
    logic [31:0]        w_wdata;
    logic [31:0]        w_pc32, w_bp32, w_sp32;

    assign w_prod  = 38'(r_s1) * 38'(KR);
    assign w_rem16 = r_s1d - 16'(r_qi) * 16'(REG_COUNT);

    assign w_sa     = r_a;
    assign w_sb     = r_b;
    assign w_tsum   = $signed({{(34 - SPW){1'b0}}, r_cur}) + 34'($signed(r_m));
    assign w_isum   = $signed({{(34 - SPW){1'b0}}, r_sp}) + 34'($signed(r_m));
    assign w_t_ok   = (w_tsum >= 0) && (w_tsum < SD34);
    assign w_i_ok   = (w_isum >= 0) && (w_isum < SD34);
    assign w_m_code = r_m < 32'(CODE_DEPTH);
    assign w_npc    = (r_pc == PCW'(CODE_DEPTH - 1)) ? '0 : r_pc + PCW'(1);
    assign w_sp4    = {1'b0, r_sp} + (SPW + 1)'(4);
    assign w_cur1   = {1'b0, r_cur} + (SPW + 1)'(1);
    assign w_bp3    = {1'b0, r_bp} + (SPW + 1)'(3);

    // restoring divide step on magnitudes
    assign w_shift = {r_rem, r_dvd[31]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_quot  = r_qneg ? 32'd0 - r_dvd : r_dvd;
    assign w_remv  = r_rneg ? 32'd0 - r_rem : r_rem;

    always_comb begin
        n_err   = ERR_NONE;
        n_wreg  = 1'b0;
        n_wval  = '0;
        n_pc    = w_npc;
        n_bp    = r_bp;
        n_sp    = r_sp;
        n_stop  = 1'b0;
        n_outv  = 1'b0;
        n_oval  = '0;
        n_event = EV_NONE;
        n_sto   = 1'b0;
        case (r_op)
            OP_LIT: begin
                n_wreg = 1'b1;
                n_wval = r_m;
            end
            OP_RTN: begin
                if (r_nb >= 32'(STACK_DEPTH)) begin
                    n_err = ERR_STACK;
                end else if (r_q >= 32'(CODE_DEPTH)) begin
                    n_err = ERR_PC;
                end else begin
                    n_sp    = r_bp - SPW'(1);
                    n_bp    = r_nb[SPW-1:0];
                    n_pc    = r_q[PCW-1:0];
                    n_event = EV_RET;
                    n_stop  = (r_q == '0);
                end
            end
            OP_LOD: begin
                if (!w_t_ok) begin
                    n_err = ERR_STACK;
                end else begin
                    n_wreg = 1'b1;
                    n_wval = r_q;
                end
            end
            OP_STO: begin
                if (!w_t_ok) n_err = ERR_STACK;
                else         n_sto = 1'b1;
            end
            OP_CAL: begin
                if (w_sp4 >= SDW) begin
                    n_err = ERR_STACK;
                end else if (!w_m_code) begin
                    n_err = ERR_PC;
                end else begin
                    n_bp    = r_sp + SPW'(1);
                    n_pc    = r_m[PCW-1:0];
                    n_event = EV_CALL;
                end
            end
            OP_INC: begin
                if (!w_i_ok) n_err = ERR_STACK;
                else         n_sp  = w_isum[SPW-1:0];
            end
            OP_JMP, OP_JPC: begin
                if (!(r_op == OP_JPC && r_rv != '0)) begin
                    if (!w_m_code) n_err = ERR_PC;
                    else           n_pc  = r_m[PCW-1:0];
                end
            end
            OP_OUT: begin
                n_outv = 1'b1;
                n_oval = r_rv;
            end
            OP_IN: begin
                n_wreg = 1'b1;
                n_wval = r_inv;
            end
            OP_HLT: n_stop = 1'b1;
            OP_NEG: begin
                n_wreg = 1'b1;
                n_wval = 32'd0 - r_a;
            end
            OP_ADD: begin
                n_wreg = 1'b1;
                n_wval = r_a + r_b;
            end
            OP_SUB: begin
                n_wreg = 1'b1;
                n_wval = r_a - r_b;
            end
            OP_MUL: begin
                n_wreg = 1'b1;
                n_wval = r_a * r_b;
            end
            OP_DIV, OP_MOD: begin
                if (r_b == '0) begin
                    n_err = ERR_ZDIV;
                end else begin
                    n_wreg = 1'b1;
                    n_wval = (r_op == OP_DIV) ? w_quot : w_remv;
                end
            end
            OP_ODD: begin
                n_wreg = 1'b1;
                n_wval = r_rv[0] ? (r_rv[31] ? 32'hFFFF_FFFF : 32'd1) : 32'd0;
            end
            OP_EQL: begin
                n_wreg = 1'b1;
                n_wval = {31'd0, w_sa == w_sb};
            end
            OP_NEQ: begin
                n_wreg = 1'b1;
                n_wval = {31'd0, w_sa != w_sb};
            end
            OP_LSS: begin
                n_wreg = 1'b1;
                n_wval = {31'd0, w_sa < w_sb};
            end
            OP_LEQ: begin
                n_wreg = 1'b1;
                n_wval = {31'd0, w_sa <= w_sb};
            end
            OP_GTR: begin
                n_wreg = 1'b1;
                n_wval = {31'd0, w_sa > w_sb};
            end
            OP_GEQ: begin
                n_wreg = 1'b1;
                n_wval = {31'd0, w_sa >= w_sb};
            end
            default: n_err = ERR_OPCODE;
        endcase
    end

    // stack port mux
    assign w_clr_stk = i_cmd.clr && (32'(r_clr) < 32'(STACK_DEPTH));
    assign w_clr_rf  = i_cmd.clr && (32'(r_clr) < 32'(REG_COUNT));

    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_addr  = '0;
        w_wdata = '0;
        if (w_clr_stk) begin
            w_we   = 1'b1;
            w_addr = r_clr[SPW-1:0];
        end else if (i_cmd.exec && n_err == ERR_NONE && n_sto) begin
            w_we    = 1'b1;
            w_addr  = w_tsum[SPW-1:0];
            w_wdata = r_rv;
        end else if (i_cmd.cal_wr) begin
            w_we   = 1'b1;
            w_addr = r_sp + SPW'(1) + SPW'(r_k);
            case (r_k)
                2'd0:    w_wdata = '0;
                2'd1:    w_wdata = 32'(r_cur);
                2'd2:    w_wdata = 32'(r_cal_bp);
                default: w_wdata = 32'(r_cal_ret);
            endcase
        end else if (i_cmd.walk_rd) begin
            w_re   = 1'b1;
            w_addr = w_cur1[SPW-1:0];
        end else if (i_cmd.lod_rd) begin
            w_re   = 1'b1;
            w_addr = w_tsum[SPW-1:0];
        end else if (i_cmd.rtn_rd3) begin
            w_re   = 1'b1;
            w_addr = r_bp + SPW'(2);
        end else if (i_cmd.rtn_rd4) begin
            w_re   = 1'b1;
            w_addr = r_bp + SPW'(3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_stack[w_addr] <= w_wdata;
        if (w_re) r_q <= r_stack[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_clr_rf) begin
            r_rf[r_clr[RW-1:0]] <= '0;
        end else if (i_cmd.exec && n_err == ERR_NONE && n_wreg) begin
            r_rf[r_ir] <= n_wval;
        end
        if (i_cmd.rd_ab) begin
            r_a <= r_rf[r_ia];
            r_b <= r_rf[r_ib];
        end
        if (i_cmd.rd_r) r_rv <= r_rf[r_ir];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_bp   <= SPW'(1);
            r_sp   <= '0;
            r_halt <= 1'b0;
            r_clr  <= '0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + CW'(1);
            if (i_cmd.stack_fault) r_halt <= 1'b1;
            if (i_cmd.exec) begin
                if (n_err != ERR_NONE) begin
                    r_halt <= 1'b1;
                end else begin
                    r_pc <= n_pc;
                    r_bp <= n_bp;
                    r_sp <= n_sp;
                    if (n_stop) r_halt <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_opcode;
            r_lv  <= i_level;
            r_m   <= i_operand_m;
            r_inv <= i_in_value;
            r_ir  <= f_small_mod(i_reg_index);
            r_ia  <= f_small_mod(i_level);
        end
        // fold M into a register number through r_s1, then r_s1d and r_qi, then r_ib
        r_s1  <= 16'(r_m[7:0]) + 16'(r_m[15:8]) * 16'(C1)
               + 16'(r_m[23:16]) * 16'(C2) + 16'(r_m[31:24]) * 16'(C3);
        r_s1d <= r_s1;
        r_qi  <= w_prod[36:23];
        r_ib  <= w_rem16[RW-1:0];

        if (i_cmd.rd_ab) begin
            r_cur <= r_bp;
            r_cnt <= r_lv;
        end
        if (i_cmd.walk_take) begin
            r_cur <= r_q[SPW-1:0];
            r_cnt <= r_cnt - 4'd1;
        end
        if (i_cmd.rtn_rd4) r_nb <= r_q;

        if (i_cmd.div_start) begin
            r_dvd  <= r_a[31] ? 32'd0 - r_a : r_a;
            r_dvs  <= r_b[31] ? 32'd0 - r_b : r_b;
            r_rem  <= '0;
            r_dcnt <= 5'd31;
            r_qneg <= r_a[31] ^ r_b[31];
            r_rneg <= r_a[31];
        end else if (i_cmd.div_step) begin
            if (!w_diff[32]) begin
                r_rem <= w_diff[31:0];
                r_dvd <= {r_dvd[30:0], 1'b1};
            end else begin
                r_rem <= w_shift[31:0];
                r_dvd <= {r_dvd[30:0], 1'b0};
            end
            r_dcnt <= r_dcnt - 5'd1;
        end

        if (i_cmd.cal_wr) r_k <= r_k + 2'd1;

        if (i_cmd.show_halt || i_cmd.stack_fault) begin
            r_err   <= i_cmd.stack_fault ? ERR_STACK : ERR_NONE;
            r_outv  <= 1'b0;
            r_oval  <= '0;
            r_event <= EV_NONE;
        end else if (i_cmd.exec) begin
            r_k <= 2'd0;
            if (n_err != ERR_NONE) begin
                r_err   <= n_err;
                r_outv  <= 1'b0;
                r_oval  <= '0;
                r_event <= EV_NONE;
            end else begin
                r_err     <= ERR_NONE;
                r_outv    <= n_outv;
                r_oval    <= n_oval;
                r_event   <= n_event;
                r_cal_bp  <= r_bp;
                r_cal_ret <= w_npc;
            end
        end
    end

    always_comb begin
        o_stat               = '0;
        o_stat.op            = r_op;
        o_stat.halted        = r_halt;
        o_stat.clr_last      = (r_clr == CW'(CLR_N - 1));
        o_stat.walk_zero     = (r_cnt == 4'd0);
        o_stat.walk_addr_bad = (w_cur1 >= SDW);
        o_stat.link_bad      = (r_q >= 32'(STACK_DEPTH));
        o_stat.lod_bad       = !w_t_ok;
        o_stat.rtn_bad       = (r_bp == '0) || (w_bp3 >= SDW);
        o_stat.b_zero        = (r_b == '0);
        o_stat.div_last      = (r_dcnt == 5'd0);
        o_stat.cal_go        = (r_op == OP_CAL) && (n_err == ERR_NONE);
        o_stat.cal_last      = (r_k == 2'd3);
    end

    assign w_pc32        = 32'(r_pc);
    assign w_bp32        = 32'(r_bp);
    assign w_sp32        = 32'(r_sp);
    assign o_pc_out      = w_pc32[8:0];
    assign o_bp_out      = w_bp32[10:0];
    assign o_sp_out      = w_sp32[10:0];
    assign o_out_valid   = r_outv;
    assign o_out_value   = r_oval;
    assign o_halted      = r_halt;
    assign o_error_code  = r_err;
    assign o_frame_event = r_event;

endmodule

[design/pl0rme_chk.sv]
module pl0rme_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [8:0]  o_pc_out,
    input logic        o_out_valid,
    input logic        o_halted,
    input logic [2:0]  o_error_code,
    input logic [1:0]  o_frame_event
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pc_out) && $stable(o_error_code))
        else $error("result changed while stalled");

    // one item in flight
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while result pending");

    // an error halts and carries no side effects
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code != 3'd0 |->
            o_halted && o_frame_event == 2'd0 && !o_out_valid)
        else $error("error result not clean");

    // only reset leaves halt
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_halted) |-> $past(!i_rst_n))
        else $error("halt cleared without reset");

endmodule

bind pl0_register_machine_execute_top pl0rme_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_pc_out      (o_pc_out),
    .o_out_valid   (o_out_valid),
    .o_halted      (o_halted),
    .o_error_code  (o_error_code),
    .o_frame_event (o_frame_event)
);

[tb/pl0_register_machine_execute_top_tb.sv]
module pl0_register_machine_execute_top_tb;
    import pl0rme_pkg::*;

    localparam int STACK_DEPTH = 2048;
    localparam int CODE_DEPTH  = 512;
    localparam int RANDOM_ITEMS = 1420;
    localparam int QUIET_ITEMS = 150;
    localparam int STALL_LIMIT = 6000;

    // one machine status, as the block reports it after each item
    typedef struct packed {
        logic [8:0]  pc;
        logic [10:0] bp;
        logic [10:0] sp;
        logic        out_valid;
        logic [31:0] out_value;
        logic        halted;
        logic [2:0]  err;
        logic [1:0]  ev;
    } status_t;

    typedef struct {
        logic [4:0]  op;
        logic [3:0]  r;
        logic [3:0]  lv;
        logic [31:0] m;
        logic [31:0] inv;
        bit          typed;
        status_t     want;
    } instr_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [4:0]  i_opcode = '0;
    logic [3:0]  i_reg_index = '0;
    logic [3:0]  i_level = '0;
    logic signed [31:0] i_operand_m = '0;
    logic signed [31:0] i_in_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [8:0]  o_pc_out;
    logic [10:0] o_bp_out;
    logic [10:0] o_sp_out;
    logic        o_out_valid;
    logic signed [31:0] o_out_value;
    logic        o_halted;
    logic [2:0]  o_error_code;
    logic [1:0]  o_frame_event;

    pl0_register_machine_execute_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_opcode(i_opcode), .i_reg_index(i_reg_index), .i_level(i_level),
        .i_operand_m(i_operand_m), .i_in_value(i_in_value),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_pc_out(o_pc_out), .o_bp_out(o_bp_out), .o_sp_out(o_sp_out),
        .o_out_valid(o_out_valid), .o_out_value(o_out_value), .o_halted(o_halted),
        .o_error_code(o_error_code), .o_frame_event(o_frame_event)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // shadow copy of the machine
    logic [31:0] mach_regs [16];
    logic [31:0] mach_stack [STACK_DEPTH];
    logic [8:0]  mach_pc = '0;
    logic [10:0] mach_bp = 11'd1;
    logic [10:0] mach_sp = '0;
    bit          mach_halted = 1'b0;

    status_t expected_status_q [$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;
    int  op_hits [32];
    int  err_hits [5];

    function automatic bit in_stack(longint a);
        return a >= 0 && a < STACK_DEPTH;
    endfunction

    function automatic longint sext(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    // Execute one instruction on the shadow machine; with commit clear, only look.
    function automatic status_t run_instruction(input logic [4:0] op, input logic [3:0] r,
                                                input logic [3:0] lv, input logic [31:0] m,
                                                input logic [31:0] inv, input bit commit);
        status_t     res;
        logic [8:0]  npc;
        logic [10:0] nbp, nsp;
        logic [2:0]  err;
        logic [1:0]  ev;
        bit          wreg, stop, outv;
        logic [31:0] wval, oval;
        longint      a, bsrc, b, t, cur, ms, nb, np;
        int          nw;
        logic [10:0] waddr [4];
        logic [31:0] wdata [4];
        res = '0;
        if (mach_halted) begin
            res.pc = mach_pc; res.bp = mach_bp; res.sp = mach_sp; res.halted = 1'b1;
            return res;
        end
        npc = mach_pc + 9'd1;
        nbp = mach_bp; nsp = mach_sp;
        err = ERR_NONE; ev = EV_NONE; nw = 0;
        wreg = 0; stop = 0; outv = 0; wval = '0; oval = '0; b = 0;
        a = sext(mach_regs[lv]);
        bsrc = sext(mach_regs[m[3:0]]);
        ms = sext(m);
        // static-link walk for load, store and call
        if (op == OP_LOD || op == OP_STO || op == OP_CAL) begin
            cur = mach_bp;
            for (int k = 0; k < lv && err == ERR_NONE; k++) begin
                if (!in_stack(cur + 1)) err = ERR_STACK;
                else begin
                    cur = sext(mach_stack[cur + 1]);
                    if (!in_stack(cur)) err = ERR_STACK;
                end
            end
            b = cur;
        end
        case (op)
            OP_LIT: begin wreg = 1; wval = m; end
            OP_RTN: begin
                if (mach_bp == 0 || !in_stack(longint'(mach_bp) + 3)) err = ERR_STACK;
                else begin
                    nb = sext(mach_stack[mach_bp + 2]);
                    np = sext(mach_stack[mach_bp + 3]);
                    if (!in_stack(nb)) err = ERR_STACK;
                    else if (np < 0 || np >= CODE_DEPTH) err = ERR_PC;
                    else begin
                        nsp = mach_bp - 11'd1; nbp = nb[10:0]; npc = np[8:0];
                        ev = EV_RET; stop = (np == 0);
                    end
                end
            end
            OP_LOD, OP_STO: if (err == ERR_NONE) begin
                t = b + ms;
                if (!in_stack(t)) err = ERR_STACK;
                else if (op == OP_LOD) begin wreg = 1; wval = mach_stack[t]; end
                else begin waddr[0] = t[10:0]; wdata[0] = mach_regs[r]; nw = 1; end
            end
            OP_CAL: if (err == ERR_NONE) begin
                if (!in_stack(longint'(mach_sp) + 4)) err = ERR_STACK;
                else if (ms < 0 || ms >= CODE_DEPTH) err = ERR_PC;
                else begin
                    waddr[0] = mach_sp + 11'd1; wdata[0] = '0;
                    waddr[1] = mach_sp + 11'd2; wdata[1] = b[31:0];
                    waddr[2] = mach_sp + 11'd3; wdata[2] = 32'(mach_bp);
                    waddr[3] = mach_sp + 11'd4; wdata[3] = 32'(npc);
                    nw = 4; nbp = mach_sp + 11'd1; npc = m[8:0]; ev = EV_CALL;
                end
            end
            OP_INC: begin
                t = longint'(mach_sp) + ms;
                if (!in_stack(t)) err = ERR_STACK; else nsp = t[10:0];
            end
            OP_JMP, OP_JPC: begin
                if (!(op == OP_JPC && mach_regs[r] != 0)) begin
                    if (ms < 0 || ms >= CODE_DEPTH) err = ERR_PC; else npc = m[8:0];
                end
            end
            OP_OUT: begin outv = 1; oval = mach_regs[r]; end
            OP_IN:  begin wreg = 1; wval = inv; end
            OP_HLT: stop = 1;
            OP_NEG: begin wreg = 1; wval = 32'(-a); end
            OP_ADD: begin wreg = 1; wval = 32'(a + bsrc); end
            OP_SUB: begin wreg = 1; wval = 32'(a - bsrc); end
            OP_MUL: begin wreg = 1; wval = 32'(a * bsrc); end
            OP_DIV, OP_MOD: begin
                if (bsrc == 0) err = ERR_ZDIV;
                else begin wreg = 1; wval = (op == OP_DIV) ? 32'(a / bsrc) : 32'(a % bsrc); end
            end
            OP_ODD: begin wreg = 1; wval = 32'(sext(mach_regs[r]) % 2); end
            OP_EQL: begin wreg = 1; wval = 32'(a == bsrc); end
            OP_NEQ: begin wreg = 1; wval = 32'(a != bsrc); end
            OP_LSS: begin wreg = 1; wval = 32'(a < bsrc); end
            OP_LEQ: begin wreg = 1; wval = 32'(a <= bsrc); end
            OP_GTR: begin wreg = 1; wval = 32'(a > bsrc); end
            OP_GEQ: begin wreg = 1; wval = 32'(a >= bsrc); end
            default: err = ERR_OPCODE;
        endcase
        if (err != ERR_NONE) begin
            // fault: hold every register, raise only the halt flag
            if (commit) mach_halted = 1'b1;
            res.pc = mach_pc; res.bp = mach_bp; res.sp = mach_sp;
            res.halted = 1'b1; res.err = err;
            return res;
        end
        if (commit) begin
            for (int k = 0; k < nw; k++) mach_stack[waddr[k]] = wdata[k];
            if (wreg) mach_regs[r] = wval;
            mach_pc = npc; mach_bp = nbp; mach_sp = nsp;
            if (stop) mach_halted = 1'b1;
        end
        res.pc = npc; res.bp = nbp; res.sp = nsp;
        res.out_valid = outv; res.out_value = oval;
        res.halted = stop; res.ev = ev;
        return res;
    endfunction

    // Drive one item, with an optional idle burst ahead of it, and hold until taken.
    task automatic send_instr(input logic [4:0] op, input logic [3:0] r, input logic [3:0] lv,
                              input logic [31:0] m, input logic [31:0] inv,
                              input bit typed, input status_t want);
        status_t pred;
        int      gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op; i_reg_index <= r; i_level <= lv;
        i_operand_m <= m; i_in_value <= inv;
        do @(posedge i_clk); while (!o_ready);
        pred = run_instruction(op, r, lv, m, inv, 1'b1);
        expected_status_q.push_back(typed ? want : pred);
        op_hits[op]++;
        if (pred.err <= ERR_PC) err_hits[pred.err]++;
        items_sent++;
    endtask

    // Draw a random instruction that keeps the machine running.
    task automatic send_random_instr();
        logic [4:0]  op;
        logic [3:0]  r, lv;
        logic [31:0] m, inv;
        status_t     look;
        int          pick;
        for (int tries = 0; tries < 40; tries++) begin
            pick = $urandom_range(0, 99);
            r = 4'($urandom); lv = 4'($urandom); m = $urandom; inv = $urandom;
            if (pick < 10) begin
                op = OP_LIT;
                case ($urandom_range(0, 3))
                    0: m = 32'h8000_0000 | 32'($urandom_range(0, 1));
                    1: m = 32'h7fff_ffff - 32'($urandom_range(0, 1));
                    2: m = 32'($urandom_range(0, 4)) - 32'd2;
                    default: ;
                endcase
            end else if (pick < 20) begin
                op = (pick < 15) ? OP_LOD : OP_STO;
                lv = 4'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 2));
                m = 32'($urandom_range(0, 40)) - 32'd8;
            end else if (pick < 26) begin
                op = OP_CAL;
                lv = 4'($urandom_range(0, 3));
                m = 32'($urandom_range(1, CODE_DEPTH - 1));
            end else if (pick < 32) op = OP_RTN;
            else if (pick < 38) begin
                op = OP_INC;
                m = 32'($urandom_range(0, 12)) - 32'd4;
            end else if (pick < 44) begin
                op = (pick < 41) ? OP_JMP : OP_JPC;
                m = 32'($urandom_range(0, CODE_DEPTH - 1));
            end else if (pick < 50) op = (pick < 47) ? OP_OUT : OP_IN;
            else op = 5'($urandom_range(OP_NEG, OP_GEQ));
            look = run_instruction(op, r, lv, m, inv, 1'b0);
            if (look.err == ERR_NONE && !look.halted) break;
            op = OP_IN;
        end
        send_instr(op, r, lv, m, inv, 1'b0, '0);
    endtask

    // Result side: random stall bursts, none once the run goes quiet.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 3);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Check each result against the oldest expectation; watch for a stuck block.
    always @(posedge i_clk) begin
        status_t got, want;
        if (o_valid && i_ready) begin
            got = '{o_pc_out, o_bp_out, o_sp_out, o_out_valid, o_out_value,
                    o_halted, o_error_code, o_frame_event};
            results_seen++;
            if (expected_status_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: pc=%0d bp=%0d sp=%0d", got.pc, got.bp, got.sp);
            end else begin
                want = expected_status_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d mismatch: exp pc=%0d bp=%0d sp=%0d ov=%0b ",
                                  "oval=%h h=%0b err=%0d ev=%0d / got pc=%0d bp=%0d sp=%0d ",
                                  "ov=%0b oval=%h h=%0b err=%0d ev=%0d"}, results_seen,
                                 want.pc, want.bp, want.sp, want.out_valid, want.out_value,
                                 want.halted, want.err, want.ev, got.pc, got.bp, got.sp,
                                 got.out_valid, got.out_value, got.halted, got.err, got.ev);
                end
            end
        end
        if ((o_valid && i_ready) || (i_valid && o_ready)) idle_cycles <= 0;
        else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("pl0_register_machine_execute_top_tb: errors");
            $finish;
        end else idle_cycles <= idle_cycles + 1;
    end

    instr_row_t directed [$];

    function automatic status_t st(int pc, int bp, int sp, bit ov, logic [31:0] oval,
                                   bit h, logic [2:0] err, logic [1:0] ev);
        status_t s;
        s = '{9'(pc), 11'(bp), 11'(sp), ov, oval, h, err, ev};
        return s;
    endfunction

    task automatic add_row(logic [4:0] op, logic [3:0] r, logic [3:0] lv, logic [31:0] m,
                           logic [31:0] inv, bit typed = 0, status_t want = '0);
        directed.push_back('{op, r, lv, m, inv, typed, want});
    endtask

    initial begin
        int kind;
        int min_hits;
        for (int k = 0; k < 16; k++) mach_regs[k] = '0;
        for (int k = 0; k < STACK_DEPTH; k++) mach_stack[k] = '0;

        // directed table: extremes first, then every operation but HLT, and the frame path
        add_row(OP_LIT, 1, 0, 32'h8000_0000, 0, 1, st(1, 1, 0, 0, 0, 0, ERR_NONE, EV_NONE));
        add_row(OP_LIT, 2, 0, 32'hffff_ffff, 0, 1, st(2, 1, 0, 0, 0, 0, ERR_NONE, EV_NONE));
        add_row(OP_LIT, 3, 0, 32'h7fff_ffff, 0, 1, st(3, 1, 0, 0, 0, 0, ERR_NONE, EV_NONE));
        add_row(OP_OUT, 1, 0, 0, 0, 1, st(4, 1, 0, 1, 32'h8000_0000, 0, ERR_NONE, EV_NONE));
        add_row(OP_DIV, 4, 1, 2, 0);              // most negative over minus one wraps
        add_row(OP_MOD, 5, 1, 32'hffff_fff2, 0);  // register number from low bits of M
        add_row(OP_ODD, 2, 0, 0, 0);              // odd of minus one keeps the sign
        add_row(OP_MUL, 6, 3, 3, 0);
        add_row(OP_ADD, 7, 1, 3, 0);
        add_row(OP_SUB, 8, 1, 3, 0);
        add_row(OP_NEG, 9, 1, 0, 0);
        for (int k = OP_EQL; k <= OP_GEQ; k++) add_row(5'(k), 10, 1, 3, 0);
        add_row(OP_IN, 11, 0, 0, 32'ha5a5_5a5a);
        add_row(OP_INC, 0, 0, 6, 0, 1, st(19, 1, 6, 0, 0, 0, ERR_NONE, EV_NONE));
        add_row(OP_STO, 3, 0, 4, 0);
        add_row(OP_LOD, 12, 0, 4, 0);
        add_row(OP_JMP, 0, 0, CODE_DEPTH - 1, 0); // next pc wraps to zero
        add_row(OP_IN, 14, 0, 0, 32'h0000_0001);
        add_row(OP_CAL, 0, 0, 40, 0);
        add_row(OP_INC, 0, 0, 5, 0);
        add_row(OP_LOD, 13, 1, 4, 0);             // one static link up
        add_row(OP_JPC, 0, 0, 100, 0);
        add_row(OP_RTN, 0, 0, 0, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k])
            send_instr(directed[k].op, directed[k].r, directed[k].lv, directed[k].m,
                       directed[k].inv, directed[k].typed, directed[k].want);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            send_random_instr();
        end

        // stop the machine one way, then confirm it stays stopped
        kind = $urandom_range(0, 4);
        case (kind)
            0: send_instr(OP_HLT, 0, 0, 0, 0, 1'b0, '0);
            1: send_instr(5'($urandom_range(25, 31)), 0, 0, 0, 0, 1'b0, '0);
            2: begin
                send_instr(OP_LIT, 15, 0, 0, 0, 1'b0, '0);
                send_instr(OP_MOD, 1, 1, 15, 0, 1'b0, '0);
            end
            3: send_instr(OP_JMP, 0, 0, CODE_DEPTH, 0, 1'b0, '0);
            default: send_instr(OP_INC, 0, 0, -STACK_DEPTH, 0, 1'b0, '0);
        endcase
        send_instr(5'd0, 0, 0, 0, 0, 1'b0, '0);
        repeat (4) send_random_instr();
        i_valid <= 1'b0;

        while (expected_status_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        min_hits = op_hits[1];
        for (int k = 2; k <= 24; k++)
            if (op_hits[k] < min_hits) min_hits = op_hits[k];
        $display("ran %0d instructions, %0d results; ops 1..24 hit min %0d times",
                 items_sent, results_seen, min_hits);
        $display("faults seen: opcode %0d, divisor %0d, stack %0d, pc %0d",
                 err_hits[ERR_OPCODE], err_hits[ERR_ZDIV], err_hits[ERR_STACK], err_hits[ERR_PC]);
        if (mismatches == 0)
            $display("pl0_register_machine_execute_top_tb: clean");
        else
            $display("pl0_register_machine_execute_top_tb: errors");
        $finish;
    end

endmodule

[sim.f]
design/pl0rme_pkg.sv
design/pl0rme_ctrl.sv
design/pl0rme_dp.sv
design/pl0_register_machine_execute_top.sv
design/pl0rme_chk.sv
tb/pl0_register_machine_execute_top_tb.sv
